// ===== sv/assert_macros.svh =====
// Assertion macros used by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset
`define TCCW_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define TCCW_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== sv/tccw_pkg.sv =====
// Types, constants and helpers of the text console cursor writer.
package tccw_pkg;

	// Port field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CH_W   = 8;
	localparam int LOC_W  = 12;
	localparam int CFG_W  = 8;
	localparam int IDX_CFG_W = 2;

	// Working widths: stored cursor, pre-wrap cursor, effective sizes, linear index
	localparam int SCOL_W = 7;
	localparam int SROW_W = 6;
	localparam int PCOL_W = 8;
	localparam int PROW_W = 7;
	localparam int EROW_W = 7;
	localparam int IDX_W  = 14;

	localparam int TAB_STEP = 4;

	localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CH_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CH_W-1:0] RESET_ATTR = 8'h07;

	// Configuration register indexes
	localparam logic [IDX_CFG_W-1:0] REG_TEXT_ATTR   = 2'd0;
	localparam logic [IDX_CFG_W-1:0] REG_CURSOR_ATTR = 2'd1;
	localparam logic [IDX_CFG_W-1:0] REG_COLUMNS     = 2'd2;
	localparam logic [IDX_CFG_W-1:0] REG_ROWS        = 2'd3;

	typedef enum logic [2:0] {
		MODE_PUT   = 3'd0,
		MODE_BS    = 3'd1,
		MODE_CLEAR = 3'd2,
		MODE_MOVE  = 3'd3,
		MODE_SHOW  = 3'd4,
		MODE_HIDE  = 3'd5,
		MODE_READ  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_RENDER
	} state_t;

	// One screen cell: attribute in the upper byte
	typedef struct packed {
		logic [CH_W-1:0] attr;
		logic [CH_W-1:0] ch;
	} cell_t;

	// Outcome of the first step of a request
	typedef struct packed {
		logic [SCOL_W-1:0] col;
		logic [SROW_W-1:0] row;
		logic              clr;
		logic              render;
		logic              vis;
		logic              hide;
		logic              we;
		logic              rd;
		cell_t             wdata;
		logic [IDX_W-1:0]  idx;
	} act_t;

	// Linear cell index row*cols+col
	function automatic logic [IDX_W-1:0] lin_idx(input logic [PROW_W-1:0] r,
			input logic [PCOL_W-1:0] c, input logic [PCOL_W-1:0] cols);
		logic [PROW_W+PCOL_W-1:0] p;
		logic [PROW_W+PCOL_W-1:0] s;
		p = (PROW_W+PCOL_W)'(r) * (PROW_W+PCOL_W)'(cols);
		s = p + (PROW_W+PCOL_W)'(c);
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== sv/tccw_ram.sv =====
// Screen cell store: one write port, one registered read port.
module tccw_ram
	import tccw_pkg::*;
#(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  cell_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output cell_t         rdata
);

	cell_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/tccw_step.sv =====
// First step of a request: cell write or read address, cursor move and wrap.
module tccw_step
	import tccw_pkg::*;
(
	input  logic [2:0]        mode,
	input  logic [CH_W-1:0]   char_code,
	input  logic [COL_W-1:0]  column,
	input  logic [ROW_W-1:0]  row,
	input  logic [SCOL_W-1:0] cur_col,
	input  logic [SROW_W-1:0] cur_row,
	input  logic [PCOL_W-1:0] eff_cols,
	input  logic [EROW_W-1:0] eff_rows,
	input  logic              visible,
	input  logic [CH_W-1:0]   text_attr,
	input  logic [CH_W-1:0]   cursor_attr,
	output act_t              act
);

	logic [PCOL_W-1:0] pc;
	logic [PROW_W-1:0] pr;
	logic [PCOL_W-1:0] wc;
	logic [PROW_W-1:0] wr;
	logic [PROW_W-1:0] op_row;
	logic [PCOL_W-1:0] op_col;
	logic              recal;

	always_comb begin
		pc          = PCOL_W'(cur_col);
		pr          = PROW_W'(cur_row);
		op_row      = PROW_W'(cur_row);
		op_col      = PCOL_W'(cur_col);
		recal       = 1'b0;
		act         = '0;
		act.vis     = visible;
		act.wdata   = '{attr: text_attr, ch: char_code};

		// mode specific move and cell access
		unique case (mode_t'(mode))
			MODE_PUT: begin
				recal = 1'b1;
				if (char_code == CH_NEWLINE) begin
					pr = PROW_W'(cur_row) + 7'd1;
					pc = '0;
				end else if (char_code == CH_TAB) begin
					if (PCOL_W'(cur_col) + PCOL_W'(TAB_STEP + 1) < eff_cols) begin
						pc = PCOL_W'(cur_col) + PCOL_W'(TAB_STEP);
					end
				end else begin
					act.we = 1'b1;
					pc     = PCOL_W'(cur_col) + 8'd1;
				end
			end
			MODE_BS: begin
				recal = 1'b1;
				if (cur_col != '0) begin
					pc        = PCOL_W'(cur_col) - 8'd1;
					op_col    = pc;
					act.we    = 1'b1;
					act.wdata = '{attr: cursor_attr, ch: CH_SPACE};
				end else if (cur_row != '0) begin
					pc = eff_cols - 8'd1;
					pr = PROW_W'(cur_row) - 7'd1;
				end
			end
			MODE_CLEAR: begin
				act.clr = 1'b1;
			end
			MODE_MOVE: begin
				recal = 1'b1;
				pc    = PCOL_W'(column);
				pr    = PROW_W'(row);
			end
			MODE_SHOW: begin
				act.vis = 1'b1;
			end
			MODE_HIDE: begin
				act.vis  = 1'b0;
				act.hide = 1'b1;
				op_row   = eff_rows;
				op_col   = eff_cols;
			end
			MODE_READ: begin
				op_row = PROW_W'(row);
				op_col = PCOL_W'(column);
				act.rd = (PCOL_W'(column) < eff_cols) && (EROW_W'(row) < eff_rows);
			end
			default: begin
			end
		endcase

		// single wrap at the right edge, then saturate
		wc = pc;
		wr = pr;
		if (pc >= eff_cols) begin
			wc = pc - eff_cols;
			wr = pr + 7'd1;
		end
		if (wc >= eff_cols) begin
			wc = eff_cols - 8'd1;
		end
		if (recal && (wr >= eff_rows)) begin
			act.clr = 1'b1;
		end

		// cursor after the request
		if (act.clr) begin
			act.col = '0;
			act.row = '0;
		end else if (recal) begin
			act.col = wc[SCOL_W-1:0];
			act.row = wr[SROW_W-1:0];
		end else begin
			act.col = cur_col;
			act.row = cur_row;
		end

		act.render = (recal || act.clr || (mode_t'(mode) == MODE_SHOW)) && act.vis;
		act.idx    = lin_idx(op_row, op_col, eff_cols);
	end

endmodule

// ===== sv/text_console_cursor_writer.sv =====
// A request is accepted in the idle state; the render state then loads the output register
// once the output is free. Clear, or a put, backspace or move past the bottom row, first
// sweeps all MAX_COLS*MAX_ROWS cells (2000 by default). Requests are taken only when idle.
// Reset: a clearing pass over all MAX_COLS*MAX_ROWS cells fills the screen with spaces, attr 0x07;
// in_ready stays low meanwhile, configuration writes are taken throughout.
`include "assert_macros.svh"
module text_console_cursor_writer
	import tccw_pkg::*;
#(
	parameter int MAX_COLS = 80,
	parameter int MAX_ROWS = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           mode,
	input  logic [CH_W-1:0]      char_code,
	input  logic [COL_W-1:0]     column,
	input  logic [ROW_W-1:0]     row,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CH_W-1:0]      cell_char,
	output logic [CH_W-1:0]      cell_attr,
	output logic [COL_W-1:0]     cursor_column,
	output logic [ROW_W-1:0]     cursor_row,
	output logic [LOC_W-1:0]     cursor_location,
	output logic                 location_written,
	output logic                 cursor_visible,
	input  logic                 cfg_we,
	input  logic [IDX_CFG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int NCELLS = MAX_COLS * MAX_ROWS;
	localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam logic [PCOL_W-1:0] MAXC = PCOL_W'(MAX_COLS);
	localparam logic [EROW_W-1:0] MAXR = EROW_W'(MAX_ROWS);

	// configuration
	logic [CH_W-1:0]   text_attr_q;
	logic [CH_W-1:0]   cursor_attr_q;
	logic [COL_W-1:0]  cols_q;
	logic [ROW_W-1:0]  rows_q;
	logic [PCOL_W-1:0] eff_c;
	logic [EROW_W-1:0] eff_r;

	// cursor state
	logic [SCOL_W-1:0] cur_col_q;
	logic [SROW_W-1:0] cur_row_q;
	logic              vis_q;
	logic [LOC_W-1:0]  loc_q;
	logic              wrote_q;

	// sequencing
	state_t            state_q;
	state_t            state_d;
	logic [AW-1:0]     sweep_q;
	logic              sweep_last;
	logic              render_s1;
	logic              rd_s1;
	logic              in_fire;
	logic              out_load;

	act_t              act;
	logic              act_ok;
	logic              rd_ok;
	logic [IDX_W-1:0]  ridx;
	logic              ridx_ok;

	// screen RAM ports
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	cell_t             mem_wdata;
	cell_t             mem_rdata;

	logic              out_valid_q;

	// effective sizes, clamped to 1..MAX
	always_comb begin
		if (cols_q == '0) begin
			eff_c = 8'd1;
		end else if (PCOL_W'(cols_q) > MAXC) begin
			eff_c = MAXC;
		end else begin
			eff_c = PCOL_W'(cols_q);
		end
		if (rows_q == '0) begin
			eff_r = 7'd1;
		end else if (EROW_W'(rows_q) > MAXR) begin
			eff_r = MAXR;
		end else begin
			eff_r = EROW_W'(rows_q);
		end
	end

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q   <= RESET_ATTR;
			cursor_attr_q <= RESET_ATTR;
			cols_q        <= 7'd80;
			rows_q        <= 5'd25;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_ATTR:   text_attr_q   <= cfg_data;
				REG_CURSOR_ATTR: cursor_attr_q <= cfg_data;
				REG_COLUMNS:     cols_q        <= cfg_data[COL_W-1:0];
				REG_ROWS:        rows_q        <= cfg_data[ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tccw_step u_step (
		.mode        (mode),
		.char_code   (char_code),
		.column      (column),
		.row         (row),
		.cur_col     (cur_col_q),
		.cur_row     (cur_row_q),
		.eff_cols    (eff_c),
		.eff_rows    (eff_r),
		.visible     (vis_q),
		.text_attr   (text_attr_q),
		.cursor_attr (cursor_attr_q),
		.act         (act)
	);

	assign act_ok     = act.idx < IDX_W'(NCELLS);
	assign rd_ok      = act.rd && act_ok;
	assign ridx       = lin_idx(PROW_W'(cur_row_q), PCOL_W'(cur_col_q), eff_c);
	assign ridx_ok    = ridx < IDX_W'(NCELLS);
	assign sweep_last = sweep_q == AW'(NCELLS - 1);
	assign in_fire    = in_valid && in_ready;

	tccw_ram #(
		.DEPTH (NCELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_fire && rd_ok),
		.raddr (act.idx[AW-1:0]),
		.rdata (mem_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM write port and handshakes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = '{attr: RESET_ATTR, ch: CH_SPACE};
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mem_we    = act.we && act_ok;
					mem_waddr = act.idx[AW-1:0];
					mem_wdata = act.wdata;
					state_d   = act.clr ? ST_SWEEP : ST_RENDER;
				end
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_wdata = '{attr: text_attr_q, ch: CH_SPACE};
				if (sweep_last) begin
					state_d = ST_RENDER;
				end
			end
			ST_RENDER: begin
				if (!out_valid_q || out_ready) begin
					out_load  = 1'b1;
					mem_we    = render_s1 && ridx_ok;
					mem_waddr = ridx[AW-1:0];
					mem_wdata = '{attr: cursor_attr_q, ch: CH_SPACE};
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if ((state_q == ST_INIT) || (state_q == ST_SWEEP)) begin
			sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
		end
	end

	// cursor state and request flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			vis_q     <= 1'b0;
			loc_q     <= '0;
			wrote_q   <= 1'b0;
			render_s1 <= 1'b0;
			rd_s1     <= 1'b0;
		end else if (in_fire) begin
			cur_col_q <= act.col;
			cur_row_q <= act.row;
			vis_q     <= act.vis;
			wrote_q   <= act.hide;
			render_s1 <= act.render;
			rd_s1     <= rd_ok;
			if (act.hide) begin
				loc_q <= act.idx[LOC_W-1:0];
			end
		end else if (out_load && render_s1) begin
			loc_q   <= ridx[LOC_W-1:0];
			wrote_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_char        <= rd_s1 ? mem_rdata.ch : '0;
			cell_attr        <= rd_s1 ? mem_rdata.attr : '0;
			cursor_column    <= cur_col_q;
			cursor_row       <= cur_row_q[ROW_W-1:0];
			cursor_location  <= render_s1 ? ridx[LOC_W-1:0] : loc_q;
			location_written <= render_s1 || wrote_q;
			cursor_visible   <= vis_q;
		end
	end

	assign out_valid = out_valid_q;

	`TCCW_ASSERT(a_fire_next, in_fire |=> (state_q == ST_RENDER || state_q == ST_SWEEP), "request accepted but no render or sweep follows")
	`TCCW_ASSERT(a_sweep_step, (state_q == ST_SWEEP && !sweep_last) |=> (state_q == ST_SWEEP && sweep_q == $past(sweep_q) + 1'b1), "clearing sweep skipped a cell")
	`TCCW_ASSERT(a_out_from_render, $rose(out_valid_q) |-> $past(state_q) == ST_RENDER, "result presented outside render step")
	`TCCW_NEVER(a_ram_addr, mem_we && (32'(mem_waddr) >= 32'(NCELLS)), "screen write beyond the store")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the text console cursor writer: directed and random requests vs a screen model.
module tb_top;
	import tccw_pkg::*;

	localparam int MAX_COLS = 80;
	localparam int MAX_ROWS = 25;
	localparam int NCELLS = MAX_COLS * MAX_ROWS;
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct {
		logic [2:0]      mode;
		logic [CH_W-1:0]  ch;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} request_t;

	// What the block reports after one request
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [CH_W-1:0]  attr;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [LOC_W-1:0] loc;
		logic             wr;
		logic             vis;
	} status_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [2:0]           mode = '0;
	logic [CH_W-1:0]      char_code = '0;
	logic [COL_W-1:0]     column = '0;
	logic [ROW_W-1:0]     row = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CH_W-1:0]      cell_char;
	logic [CH_W-1:0]      cell_attr;
	logic [COL_W-1:0]     cursor_column;
	logic [ROW_W-1:0]     cursor_row;
	logic [LOC_W-1:0]     cursor_location;
	logic                 location_written;
	logic                 cursor_visible;
	logic                 cfg_we = 1'b0;
	logic [IDX_CFG_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	text_console_cursor_writer #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.char_code(char_code),
		.column(column),
		.row(row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_char(cell_char),
		.cell_attr(cell_attr),
		.cursor_column(cursor_column),
		.cursor_row(cursor_row),
		.cursor_location(cursor_location),
		.location_written(location_written),
		.cursor_visible(cursor_visible),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Run bookkeeping
	status_t pending_status[$];
	int requests_sent = 0;
	int results_checked = 0;
	int screen_wipes = 0;
	int mismatches = 0;
	bit gap_enable = 1'b1;
	bit stall_enable = 1'b1;
	int hold_off_cycles = 0;

	// Screen model: cells, cursor, location register and settings
	logic [15:0]      screen_model [NCELLS];
	int unsigned      cur_x;
	int unsigned      cur_y;
	logic             shown;
	logic [LOC_W-1:0] loc_model;
	logic             loc_wr;
	logic [CH_W-1:0]  text_attr_m;
	logic [CH_W-1:0]  cursor_attr_m;
	logic [6:0]       cols_m;
	logic [4:0]       rows_m;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net against a hung handshake
	initial begin
		#40_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic int unsigned model_cols();
		if (cols_m == 0)
			return 1;
		return (cols_m > MAX_COLS) ? MAX_COLS : cols_m;
	endfunction

	function automatic int unsigned model_rows();
		if (rows_m == 0)
			return 1;
		return (rows_m > MAX_ROWS) ? MAX_ROWS : rows_m;
	endfunction

	function automatic void init_console_model();
		for (int i = 0; i < NCELLS; i++)
			screen_model[i] = {RESET_ATTR, CH_SPACE};
		cur_x = 0;
		cur_y = 0;
		shown = 1'b0;
		loc_model = '0;
		loc_wr = 1'b0;
		text_attr_m = RESET_ATTR;
		cursor_attr_m = RESET_ATTR;
		cols_m = 7'd80;
		rows_m = 5'd25;
	endfunction

	// Writes past the store are dropped
	function automatic void model_put_cell(int unsigned idx, logic [CH_W-1:0] ch,
			logic [CH_W-1:0] attr);
		if (idx < NCELLS)
			screen_model[idx] = {attr, ch};
	endfunction

	function automatic void model_draw_cursor();
		int unsigned idx;
		if (shown) begin
			idx = cur_y * model_cols() + cur_x;
			model_put_cell(idx, CH_SPACE, cursor_attr_m);
			loc_model = LOC_W'(idx);
			loc_wr = 1'b1;
		end
	endfunction

	// Whole store cleared, not just the area in use
	function automatic void model_wipe();
		for (int i = 0; i < NCELLS; i++)
			model_put_cell(i, CH_SPACE, text_attr_m);
		cur_x = 0;
		cur_y = 0;
		screen_wipes++;
		model_draw_cursor();
	endfunction

	// Single wrap, column saturation, clear past the bottom, then cursor redraw
	function automatic void model_settle();
		int unsigned c;
		c = model_cols();
		if (cur_x >= c) begin
			cur_x -= c;
			cur_y++;
		end
		if (cur_x >= c)
			cur_x = c - 1;
		if (cur_y >= model_rows())
			model_wipe();
		model_draw_cursor();
	endfunction

	function automatic status_t predict_status(request_t r);
		status_t s;
		int unsigned c;
		int unsigned rws;
		int unsigned idx;
		c = model_cols();
		rws = model_rows();
		s = '0;
		loc_wr = 1'b0;
		case (r.mode)
			MODE_PUT: begin
				if (r.ch == CH_NEWLINE) begin
					cur_y++;
					cur_x = 0;
				end else if (r.ch == CH_TAB) begin
					if (cur_x + TAB_STEP + 1 < c)
						cur_x += TAB_STEP;
				end else begin
					model_put_cell(cur_y * c + cur_x, r.ch, text_attr_m);
					cur_x++;
				end
				model_settle();
			end
			MODE_BS: begin
				if (cur_x > 0) begin
					cur_x--;
					model_put_cell(cur_y * c + cur_x, CH_SPACE, cursor_attr_m);
				end else if (cur_y > 0) begin
					cur_x = c - 1;
					cur_y--;
				end
				model_settle();
			end
			MODE_CLEAR: model_wipe();
			MODE_MOVE: begin
				cur_x = r.col;
				cur_y = r.row;
				model_settle();
			end
			MODE_SHOW: begin
				shown = 1'b1;
				model_draw_cursor();
			end
			// Hide parks the location just off screen and leaves the cells alone
			MODE_HIDE: begin
				loc_model = LOC_W'(rws * c + c);
				loc_wr = 1'b1;
				shown = 1'b0;
			end
			MODE_READ: begin
				if (r.col < c && r.row < rws) begin
					idx = r.row * c + r.col;
					if (idx < NCELLS)
						{s.attr, s.ch} = screen_model[idx];
				end
			end
			default: ;
		endcase
		s.col = COL_W'(cur_x);
		s.row = ROW_W'(cur_y);
		s.loc = loc_model;
		s.wr = loc_wr;
		s.vis = shown;
		return s;
	endfunction

	function automatic request_t make_request(logic [2:0] m, logic [CH_W-1:0] ch,
			logic [COL_W-1:0] col, logic [ROW_W-1:0] rw);
		request_t r;
		r.mode = m;
		r.ch = ch;
		r.col = col;
		r.row = rw;
		return r;
	endfunction

	// Characters most often; moves and reads mostly land inside the area in use
	function automatic request_t random_request();
		request_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r.ch = CH_W'($urandom_range(0, 255));
		r.col = COL_W'($urandom_range(0, 127));
		r.row = ROW_W'($urandom_range(0, 31));
		if (pick < 45) begin
			r.mode = MODE_PUT;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				r.ch = CH_NEWLINE;
			else if (pick < 18)
				r.ch = CH_TAB;
		end else if (pick < 55)
			r.mode = MODE_BS;
		else if (pick < 58)
			r.mode = MODE_CLEAR;
		else if (pick < 70)
			r.mode = MODE_MOVE;
		else if (pick < 75)
			r.mode = MODE_SHOW;
		else if (pick < 80)
			r.mode = MODE_HIDE;
		else if (pick < 97)
			r.mode = MODE_READ;
		else
			r.mode = MODE_UNUSED;
		if ((r.mode == MODE_MOVE || r.mode == MODE_READ) && $urandom_range(0, 99) < 85) begin
			r.col = COL_W'($urandom_range(0, model_cols() - 1));
			r.row = ROW_W'($urandom_range(0, model_rows() - 1));
		end
		return r;
	endfunction

	// Offer one request and predict its status once accepted
	task automatic send_request(request_t r);
		int gap;
		gap = gap_enable ? $urandom_range(0, 19) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= r.mode;
		char_code <= r.ch;
		column <= r.col;
		row <= r.row;
		do
			@(posedge clk);
		while (!in_ready);
		pending_status.push_back(predict_status(r));
		requests_sent++;
	endtask

	task automatic send(logic [2:0] m, logic [CH_W-1:0] ch, logic [COL_W-1:0] col,
			logic [ROW_W-1:0] rw);
		send_request(make_request(m, ch, col, rw));
	endtask

	// Every request answers, so once the queue is empty the block is idle
	task automatic wait_settled();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(logic [IDX_CFG_W-1:0] index, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_TEXT_ATTR:   text_attr_m = value;
			REG_CURSOR_ATTR: cursor_attr_m = value;
			REG_COLUMNS:     cols_m = value[6:0];
			REG_ROWS:        rows_m = value[4:0];
			default: ;
		endcase
	endtask

	task automatic set_screen(logic [6:0] cols, logic [4:0] rws, logic [CH_W-1:0] tattr,
			logic [CH_W-1:0] cattr);
		wait_settled();
		write_config(REG_COLUMNS, CFG_W'(cols));
		write_config(REG_ROWS, CFG_W'(rws));
		write_config(REG_TEXT_ATTR, tattr);
		write_config(REG_CURSOR_ATTR, cattr);
	endtask

	// Reset contents, character extremes, repeated hide and the unused mode
	task automatic test_reset_state();
		send(MODE_READ, 8'h00, 7'd0, 5'd0);
		send(MODE_READ, 8'hFF, 7'd127, 5'd31);
		send(MODE_PUT, 8'hFF, 7'd0, 5'd0);
		send(MODE_PUT, 8'h00, 7'd127, 5'd31);
		send(MODE_SHOW, 8'h00, 7'd0, 5'd0);
		send(MODE_HIDE, 8'h00, 7'd0, 5'd0);
		send(MODE_HIDE, 8'hFF, 7'd127, 5'd31);
		send(MODE_UNUSED, 8'hFF, 7'd127, 5'd31);
	endtask

	// Tab, newline, backspace both ways, right-edge wrap and a clear by command, put or move
	task automatic test_cursor_editing();
		set_screen(7'd80, 5'd25, 8'hFF, 8'h00);
		send(MODE_SHOW, 8'h00, 7'd0, 5'd0);
		send(MODE_PUT, CH_TAB, 7'd0, 5'd0);
		send(MODE_PUT, CH_NEWLINE, 7'd0, 5'd0);
		send(MODE_BS, 8'h00, 7'd0, 5'd0);
		send(MODE_BS, 8'h00, 7'd0, 5'd0);
		send(MODE_MOVE, 8'h00, 7'd74, 5'd3);
		send(MODE_PUT, CH_TAB, 7'd0, 5'd0);
		send(MODE_PUT, 8'h41, 7'd0, 5'd0);
		send(MODE_PUT, 8'h42, 7'd0, 5'd0);
		send(MODE_MOVE, 8'h00, 7'd79, 5'd24);
		send(MODE_PUT, 8'h5A, 7'd0, 5'd0);
		send(MODE_CLEAR, 8'h00, 7'd0, 5'd0);
		send(MODE_MOVE, 8'h00, 7'd3, 5'd31);
	endtask

	// Stale cursor after shrinking, sizes of zero and sizes above the maximum
	task automatic test_size_limits();
		send(MODE_MOVE, 8'h00, 7'd70, 5'd5);
		wait_settled();
		write_config(REG_COLUMNS, 8'd10);
		send(MODE_PUT, 8'h71, 7'd0, 5'd0);
		send(MODE_SHOW, 8'h00, 7'd0, 5'd0);
		set_screen(7'd0, 5'd0, 8'h00, 8'hFF);
		send(MODE_PUT, 8'h21, 7'd0, 5'd0);
		send(MODE_READ, 8'h00, 7'd0, 5'd0);
		set_screen(7'd127, 5'd31, 8'h1E, 8'h70);
		send(MODE_HIDE, 8'h00, 7'd0, 5'd0);
	endtask

	// Receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		set_screen(7'd40, 5'd12, 8'h0F, 8'hF0);
		gap_enable = 1'b0;
		stall_enable = 1'b1;
		hold_off_cycles = HOLD_OFF_CYCLES;
		repeat (24) send_request(random_request());
		gap_enable = 1'b1;
	endtask

	task automatic test_random_traffic(logic [6:0] cols, logic [4:0] rws, int count, bit idling);
		set_screen(cols, rws, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)));
		gap_enable = idling;
		stall_enable = idling;
		repeat (count) send_request(random_request());
	endtask

	// Result side: random stalls per result, or one long hold-off when asked
	initial begin
		int stall;
		forever begin
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end else
				stall = stall_enable ? $urandom_range(0, 19) : 0;
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid === 1'b1 && out_ready));
		end
	end

	// One line per mismatch, and a running count
	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch at %0t ns, result %0d: %s got %0d expected %0d",
			$time, results_checked, what, got, want);
	endtask

	task automatic compare_field(string what, int got, int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		status_t got;
		status_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = {cell_char, cell_attr, cursor_column, cursor_row, cursor_location,
				location_written, cursor_visible};
			if (pending_status.size() == 0)
				report_mismatch("result with no request pending", 1, 0);
			else begin
				want = pending_status.pop_front();
				results_checked++;
				compare_field("cell_char", got.ch, want.ch);
				compare_field("cell_attr", got.attr, want.attr);
				compare_field("cursor_column", got.col, want.col);
				compare_field("cursor_row", got.row, want.row);
				compare_field("cursor_location", got.loc, want.loc);
				compare_field("location_written", got.wr, want.wr);
				compare_field("cursor_visible", got.vis, want.vis);
			end
		end
	end

	initial begin
		init_console_model();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_cursor_editing();
		test_size_limits();
		test_backpressure();
		test_random_traffic(7'd80, 5'd25, 200, 1'b1);
		test_random_traffic(7'd12, 5'd4, 130, 1'b1);
		test_random_traffic(7'd1, 5'd1, 30, 1'b1);
		test_random_traffic(7'd127, 5'd31, 120, 1'b0);
		test_random_traffic(7'd33, 5'd7, 150, 1'b1);
		test_random_traffic(7'd5, 5'd25, 80, 1'b1);

		wait_settled();
		repeat (8) @(posedge clk);

		$display("covered %0d requests over screen sizes 1x1 to 80x25, %0d screen clears",
			requests_sent, screen_wipes);
		$display("checked %0d results, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
